FILE: design/dfe_pkg.sv
package dfe_pkg;

	// position width (fixed by the point format)
	localparam int POS_BITS = 24;
	// squares, radius squared and numerators
	localparam int NW = 2 * POS_BITS;
	// dipole moment register and its magnitude
	localparam int MOM_W = 48;
	localparam int MAGW = MOM_W;
	// mm to 1/16 mm cube conversion shift (16^3)
	localparam int UNIT_SHIFT = 12;
	// dividend / quotient width
	localparam int XW = MAGW + NW + UNIT_SHIFT;
	// box compare width
	localparam int HALF_W = 24;
	localparam int CMPW = (POS_BITS > HALF_W) ? POS_BITS : HALF_W;
	// queue between front and back
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// register indexes and reset values
	localparam int REG_IDX_W = 2;
	localparam logic [REG_IDX_W-1:0] REG_PEAK = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_HLEN = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_HWID = 2'd2;
	localparam logic [REG_IDX_W-1:0] REG_MOM  = 2'd3;
	localparam logic [31:0]       PEAK_RST = 32'd65536;
	localparam logic [HALF_W-1:0] HLEN_RST = 24'd406;
	localparam logic [HALF_W-1:0] HWID_RST = 24'd406;
	localparam logic [MOM_W-1:0]  MOM_RST  = 48'd1073942626;

	typedef struct packed {
		logic signed [POS_BITS-1:0] pos_x;
		logic signed [POS_BITS-1:0] pos_y;
		logic signed [POS_BITS-1:0] pos_z;
	} point_t;

	typedef struct packed {
		logic signed [31:0] field_x;
		logic signed [31:0] field_y;
		logic signed [31:0] field_z;
		logic               in_gap;
	} field_t;

	// classified point handed from front to back
	typedef struct packed {
		logic          gap;
		logic          sx;
		logic          sy;
		logic          sz;
		logic [NW-1:0] r2;
		logic [NW-1:0] nx;
		logic [NW-1:0] nz;
		logic [NW-1:0] y3;
	} qentry_t;

endpackage

FILE: design/dipole_field_evaluator.sv
// A gap point passes front stages 1 and 2, the queue and the output register.
// Gap points stream at one per cycle while the back end is idle and fields
//   are taken; a point outside goes through the back end's bit-serial square
//   root, multiplier and divider; the next pops once its field is registered.
// A 4-entry queue lets the front keep taking points while the back end works.
// Reset: arst_n clears all control state and loads the register reset values.
module dipole_field_evaluator (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            point_valid,
	output logic                            point_ready,
	input  dfe_pkg::point_t                 point,
	output logic                            field_valid,
	input  logic                            field_ready,
	output dfe_pkg::field_t                 field,
	input  logic                            cfg_we,
	input  logic [dfe_pkg::REG_IDX_W-1:0]   cfg_idx,
	input  logic [dfe_pkg::MOM_W-1:0]       cfg_data
);

	logic [31:0] peak_q;
	logic [dfe_pkg::HALF_W-1:0] hlen_q, hwid_q;
	logic [dfe_pkg::MOM_W-1:0] mom_q;

	logic q_wr, q_rd, q_full, q_empty;
	dfe_pkg::qentry_t q_wdata, q_rdata;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			peak_q <= dfe_pkg::PEAK_RST;
			hlen_q <= dfe_pkg::HLEN_RST;
			hwid_q <= dfe_pkg::HWID_RST;
			mom_q  <= dfe_pkg::MOM_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				dfe_pkg::REG_PEAK: peak_q <= cfg_data[31:0];
				dfe_pkg::REG_HLEN: hlen_q <= cfg_data[dfe_pkg::HALF_W-1:0];
				dfe_pkg::REG_HWID: hwid_q <= cfg_data[dfe_pkg::HALF_W-1:0];
				dfe_pkg::REG_MOM:  mom_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	dfe_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.point_valid (point_valid),
		.point_ready (point_ready),
		.point       (point),
		.half_length (hlen_q),
		.half_width  (hwid_q),
		.q_full      (q_full),
		.q_wr        (q_wr),
		.q_data      (q_wdata)
	);

	dfe_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (q_wr),
		.wr_data (q_wdata),
		.full    (q_full),
		.rd      (q_rd),
		.rd_data (q_rdata),
		.empty   (q_empty)
	);

	dfe_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_empty       (q_empty),
		.q_data        (q_rdata),
		.q_rd          (q_rd),
		.peak_field    (peak_q),
		.dipole_moment (mom_q),
		.field_valid   (field_valid),
		.field_ready   (field_ready),
		.field         (field)
	);

endmodule

FILE: design/dfe_front.sv
module dfe_front (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         point_valid,
	output logic                         point_ready,
	input  dfe_pkg::point_t              point,
	input  logic [dfe_pkg::HALF_W-1:0]   half_length,
	input  logic [dfe_pkg::HALF_W-1:0]   half_width,
	input  logic                         q_full,
	output logic                         q_wr,
	output dfe_pkg::qentry_t             q_data
);

	localparam int P = dfe_pkg::POS_BITS;
	localparam int NW = dfe_pkg::NW;
	localparam int CMPW = dfe_pkg::CMPW;

	logic en1, en2;
	logic v_s1, v_s2;
	logic [P-1:0] ax, ay, az;
	logic [P-1:0] ax_s1, ay_s1, az_s1;
	logic sx_s1, sy_s1, sz_s1, gap_s1;
	logic sx_s2, sy_s2, sz_s2, gap_s2;
	logic [NW-1:0] sxx_s2, syy_s2, szz_s2, sxy_s2, szy_s2;

	// stall chain from the queue
	assign en2 = !v_s2 || !q_full;
	assign en1 = !v_s1 || en2;
	assign point_ready = en1;
	assign q_wr = v_s2 && !q_full;

	// magnitudes
	assign ax = point.pos_x[P-1] ? (~point.pos_x + 1'b1) : point.pos_x;
	assign ay = point.pos_y[P-1] ? (~point.pos_y + 1'b1) : point.pos_y;
	assign az = point.pos_z[P-1] ? (~point.pos_z + 1'b1) : point.pos_z;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (en1)
				v_s1 <= point_valid;
			if (en2)
				v_s2 <= v_s1;
		end
	end

	// stage 1: magnitudes, signs and box test
	always_ff @(posedge clk) begin
		if (en1) begin
			ax_s1  <= ax;
			ay_s1  <= ay;
			az_s1  <= az;
			sx_s1  <= point.pos_x[P-1];
			sy_s1  <= point.pos_y[P-1];
			sz_s1  <= point.pos_z[P-1];
			gap_s1 <= (CMPW'(az) <= CMPW'(half_length)) &&
				(CMPW'(ax) <= CMPW'(half_width)) &&
				(CMPW'(ay) <= CMPW'(half_width));
		end
	end

	// stage 2: products
	always_ff @(posedge clk) begin
		if (en2) begin
			sxx_s2 <= NW'(ax_s1) * NW'(ax_s1);
			syy_s2 <= NW'(ay_s1) * NW'(ay_s1);
			szz_s2 <= NW'(az_s1) * NW'(az_s1);
			sxy_s2 <= NW'(ax_s1) * NW'(ay_s1);
			szy_s2 <= NW'(az_s1) * NW'(ay_s1);
			sx_s2  <= sx_s1;
			sy_s2  <= sy_s1;
			sz_s2  <= sz_s1;
			gap_s2 <= gap_s1;
		end
	end

	// sums and times three into the queue
	always_comb begin
		q_data.gap = gap_s2;
		q_data.sx  = sx_s2;
		q_data.sy  = sy_s2;
		q_data.sz  = sz_s2;
		q_data.r2  = sxx_s2 + syy_s2 + szz_s2;
		q_data.nx  = sxy_s2 + {sxy_s2[NW-2:0], 1'b0};
		q_data.nz  = szy_s2 + {szy_s2[NW-2:0], 1'b0};
		q_data.y3  = syy_s2 + {syy_s2[NW-2:0], 1'b0};
	end

endmodule

FILE: design/dfe_queue.sv
module dfe_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr,
	input  dfe_pkg::qentry_t wr_data,
	output logic             full,
	input  logic             rd,
	output dfe_pkg::qentry_t rd_data,
	output logic             empty
);

	localparam int QD = dfe_pkg::QDEPTH;
	localparam int PW = dfe_pkg::QPTR_W;
	localparam int CW = dfe_pkg::QCNT_W;

	dfe_pkg::qentry_t mem_q [QD];
	logic [PW-1:0] wptr_q, rptr_q;
	logic [CW-1:0] cnt_q;

	assign full = (cnt_q == CW'(QD));
	assign empty = (cnt_q == '0);
	assign rd_data = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (wr)
			mem_q[wptr_q] <= wr_data;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (wr)
				wptr_q <= (wptr_q == PW'(QD - 1)) ? '0 : wptr_q + 1'b1;
			if (rd)
				rptr_q <= (rptr_q == PW'(QD - 1)) ? '0 : rptr_q + 1'b1;
			if (wr && !rd)
				cnt_q <= cnt_q + 1'b1;
			else if (rd && !wr)
				cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

FILE: design/dfe_back.sv
module dfe_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        q_empty,
	input  dfe_pkg::qentry_t            q_data,
	output logic                        q_rd,
	input  logic [31:0]                 peak_field,
	input  logic [dfe_pkg::MOM_W-1:0]   dipole_moment,
	output logic                        field_valid,
	input  logic                        field_ready,
	output dfe_pkg::field_t             field
);

	localparam int P = dfe_pkg::POS_BITS;
	localparam int NW = dfe_pkg::NW;
	localparam int MAGW = dfe_pkg::MAGW;
	localparam int XW = dfe_pkg::XW;
	localparam int CNTW = $clog2(XW);

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_SQRT = 5'b00010,
		ST_MUL  = 5'b00100,
		ST_DIV  = 5'b01000,
		ST_DONE = 5'b10000
	} bstate_t;

	bstate_t state_q;
	logic [NW-1:0] r2_q, rt_q;
	logic [NW-1:0] nmag_q [3];
	logic [2:0] neg_q;
	logic [1:0] comp_q, dsel_q;
	logic [MAGW-1:0] mm_q, mmw_q;
	logic [NW-1:0] sq_v_q, sq_res_q, sq_bit_q;
	logic [CNTW-1:0] cnt_q;
	logic [XW-1:0] acc_q;
	logic [NW-1:0] rem_q;
	logic [31:0] res_q [3];
	logic out_valid_q;
	dfe_pkg::field_t out_q;

	logic out_free;
	logic nmm;
	logic [MAGW-1:0] mm_mag;
	logic [NW-1:0] ydiff;
	logic yneg;
	logic [NW-1:0] sq_sum, sq_res_n;
	logic sq_ge;
	logic [P-1:0] r_new;
	logic [XW-1:0] mul_n;
	logic [NW-1:0] divisor;
	logic [NW:0] rem_sh;
	logic div_ge;
	logic [XW-1:0] quo_n;

	function automatic logic [31:0] sat32(input logic [XW-1:0] q, input logic neg);
		logic big;
		big = |q[XW-1:32];
		if (neg) begin
			if (big || q[31:0] > 32'h8000_0000)
				return 32'h8000_0000;
			return ~q[31:0] + 1'b1;
		end
		if (big || q[31])
			return 32'h7fff_ffff;
		return q[31:0];
	endfunction

	assign out_free = !out_valid_q || field_ready;
	assign field_valid = out_valid_q;
	assign field = out_q;

	// moment magnitude and y numerator
	assign nmm = dipole_moment[MAGW-1];
	assign mm_mag = nmm ? (~dipole_moment + 1'b1) : dipole_moment;
	assign yneg = (q_data.y3 < q_data.r2);
	assign ydiff = yneg ? (q_data.r2 - q_data.y3) : (q_data.y3 - q_data.r2);

	// pop: gap points need the output register, dipole points do not
	assign q_rd = (state_q == ST_IDLE) && !q_empty && (!q_data.gap || out_free);

	// square root digit step
	assign sq_sum = sq_res_q + sq_bit_q;
	assign sq_ge = (sq_v_q >= sq_sum);
	assign sq_res_n = sq_ge ? ((sq_res_q >> 1) + sq_bit_q) : (sq_res_q >> 1);
	assign r_new = (sq_res_n[P-1:0] == '0) ? P'(1) : sq_res_n[P-1:0];

	// shift-add multiply step, moment bits msb first
	assign mul_n = {acc_q[XW-2:0], 1'b0} + (mmw_q[MAGW-1] ? XW'(nmag_q[comp_q]) : '0);

	// restoring divide step
	assign divisor = (dsel_q == 2'd2) ? rt_q : r2_q;
	assign rem_sh = {rem_q, acc_q[XW-1]};
	assign div_ge = (rem_sh >= {1'b0, divisor});
	assign quo_n = {acc_q[XW-2:0], div_ge};

	// output register: loaded by a gap pop or a finished dipole point
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if ((q_rd && q_data.gap) || ((state_q == ST_DONE) && out_free))
			out_valid_q <= 1'b1;
		else if (field_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			comp_q      <= '0;
			dsel_q      <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (q_rd && !q_data.gap) begin
						state_q <= ST_SQRT;
					end
				end
				ST_SQRT: begin
					if (sq_bit_q[0]) begin
						state_q <= ST_MUL;
						comp_q  <= '0;
						cnt_q   <= '0;
					end
				end
				ST_MUL: begin
					if (cnt_q == CNTW'(MAGW - 1)) begin
						state_q <= ST_DIV;
						dsel_q  <= '0;
						cnt_q   <= '0;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_DIV: begin
					if (cnt_q == CNTW'(XW - 1)) begin
						cnt_q <= '0;
						if (dsel_q == 2'd2) begin
							if (comp_q == 2'd2) begin
								state_q <= ST_DONE;
							end else begin
								comp_q  <= comp_q + 1'b1;
								state_q <= ST_MUL;
							end
						end else begin
							dsel_q <= dsel_q + 1'b1;
						end
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (q_rd && q_data.gap) begin
					out_q.field_x <= '0;
					out_q.field_y <= peak_field;
					out_q.field_z <= '0;
					out_q.in_gap  <= 1'b1;
				end else if (q_rd) begin
					r2_q      <= (q_data.r2 == '0) ? NW'(1) : q_data.r2;
					nmag_q[0] <= q_data.nx;
					nmag_q[1] <= ydiff;
					nmag_q[2] <= q_data.nz;
					neg_q[0]  <= nmm ^ q_data.sx ^ q_data.sy;
					neg_q[1]  <= nmm ^ yneg;
					neg_q[2]  <= nmm ^ q_data.sz ^ q_data.sy;
					mm_q      <= mm_mag;
					sq_v_q    <= q_data.r2;
					sq_res_q  <= '0;
					sq_bit_q  <= {2'b01, {(NW - 2){1'b0}}};
				end
			end
			ST_SQRT: begin
				if (sq_ge)
					sq_v_q <= sq_v_q - sq_sum;
				sq_res_q <= sq_res_n;
				sq_bit_q <= sq_bit_q >> 2;
				if (sq_bit_q[0]) begin
					rt_q  <= NW'(r_new);
					acc_q <= '0;
					mmw_q <= mm_q;
				end
			end
			ST_MUL: begin
				mmw_q <= mmw_q << 1;
				if (cnt_q == CNTW'(MAGW - 1)) begin
					acc_q <= mul_n << dfe_pkg::UNIT_SHIFT;
					rem_q <= '0;
				end else begin
					acc_q <= mul_n;
				end
			end
			ST_DIV: begin
				if (cnt_q == CNTW'(XW - 1)) begin
					rem_q <= '0;
					if (dsel_q == 2'd2) begin
						res_q[comp_q] <= sat32(quo_n, neg_q[comp_q]);
						acc_q <= '0;
						mmw_q <= mm_q;
					end else begin
						acc_q <= quo_n;
					end
				end else begin
					acc_q <= quo_n;
					rem_q <= div_ge ? NW'(rem_sh - {1'b0, divisor}) : rem_sh[NW-1:0];
				end
			end
			ST_DONE: begin
				if (out_free) begin
					out_q.field_x <= res_q[0];
					out_q.field_y <= res_q[1];
					out_q.field_z <= res_q[2];
					out_q.in_gap  <= 1'b0;
				end
			end
			default: ;
		endcase
	end

endmodule

FILE: tb/dipole_field_evaluator_tb.sv
module dipole_field_evaluator_tb;

	localparam int CLK_HALF   = 10;
	localparam int CYCLE_CAP  = 4000000;
	localparam int RAND_ITEMS = 100;
	localparam int PB         = dfe_pkg::POS_BITS;
	localparam int MW         = dfe_pkg::MOM_W;

	logic                          clk = 1'b0;
	logic                          arst_n;
	logic                          point_valid;
	logic                          point_ready;
	dfe_pkg::point_t               point;
	logic                          field_valid;
	logic                          field_ready = 1'b0;
	dfe_pkg::field_t               field;
	logic                          cfg_we;
	logic [dfe_pkg::REG_IDX_W-1:0] cfg_idx;
	logic [MW-1:0]                 cfg_data;

	dipole_field_evaluator i_dut (
		.clk(clk), .arst_n(arst_n),
		.point_valid(point_valid), .point_ready(point_ready), .point(point),
		.field_valid(field_valid), .field_ready(field_ready), .field(field),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
	);

	// shadow copy of the register file
	logic signed [31:0]              gap_field;
	logic [dfe_pkg::HALF_W-1:0]      box_half_len;
	logic [dfe_pkg::HALF_W-1:0]      box_half_wid;
	logic signed [MW-1:0]            moment;

	dfe_pkg::field_t pending_fields[$];
	int     errors = 0;
	int     cycles = 0;
	// typed expectation attached to the point being offered
	logic   row_has_exp;
	dfe_pkg::field_t row_exp;

	// directed table
	typedef struct {
		dfe_pkg::point_t p;
		logic            has_exp;
		dfe_pkg::field_t exp;
	} row_t;
	row_t rows[$];

	always #CLK_HALF clk = ~clk;

	function automatic logic [63:0] abs_pos(logic signed [PB-1:0] v);
		logic [63:0] w;
		w = {{(64-PB){v[PB-1]}}, v};
		return v[PB-1] ? (64'd0 - w) : w;
	endfunction

	function automatic logic [63:0] int_sqrt(logic [63:0] v);
		logic [63:0] res;
		logic [63:0] cand;
		res = 0;
		for (int i = 31; i >= 0; i--) begin
			cand = res | (64'd1 << i);
			if (cand * cand <= v)
				res = cand;
		end
		return res;
	endfunction

	// one dipole component, truncated toward zero, then saturated
	function automatic logic [31:0] dipole_comp(logic [63:0] mag_m, logic [63:0] num,
			logic neg, logic [63:0] r2, logic [63:0] r);
		logic [127:0] q;
		logic [127:0] den;
		q   = ({64'd0, mag_m} * {64'd0, num}) << dfe_pkg::UNIT_SHIFT;
		den = {64'd0, r2} * {64'd0, r2} * {64'd0, r};
		q   = q / den;
		if (neg) begin
			if (q > 128'h80000000)
				return 32'h80000000;
			return 32'd0 - q[31:0];
		end
		if (q > 128'h7FFFFFFF)
			return 32'h7FFFFFFF;
		return q[31:0];
	endfunction

	function automatic dfe_pkg::field_t predict_field(dfe_pkg::point_t p);
		dfe_pkg::field_t f;
		logic [63:0] ax, ay, az, mag_m, r2, r, y3, ny;
		logic        neg_m, neg_ny;
		ax = abs_pos(p.pos_x);
		ay = abs_pos(p.pos_y);
		az = abs_pos(p.pos_z);
		if (az <= box_half_len && ax <= box_half_wid && ay <= box_half_wid) begin
			f.field_x = 0;
			f.field_y = gap_field;
			f.field_z = 0;
			f.in_gap  = 1'b1;
			return f;
		end
		neg_m = moment[MW-1];
		mag_m = neg_m ? (64'd0 - {{16{1'b1}}, moment}) : {16'd0, moment};
		r2 = ax * ax + ay * ay + az * az;
		r  = int_sqrt(r2);
		if (r == 0)
			r = 1;
		if (r2 == 0)
			r2 = 1;
		y3 = 3 * ay * ay;
		if (y3 >= r2) begin
			ny = y3 - r2;
			neg_ny = 1'b0;
		end else begin
			ny = r2 - y3;
			neg_ny = 1'b1;
		end
		f.field_x = dipole_comp(mag_m, 3 * ax * ay, neg_m ^ p.pos_x[PB-1] ^
			p.pos_y[PB-1], r2, r);
		f.field_y = dipole_comp(mag_m, ny, neg_m ^ neg_ny, r2, r);
		f.field_z = dipole_comp(mag_m, 3 * az * ay, neg_m ^ p.pos_z[PB-1] ^
			p.pos_y[PB-1], r2, r);
		f.in_gap = 1'b0;
		return f;
	endfunction

	// cycle count and timeout
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_CAP) begin
			$display("%0t: timeout", $time);
			$display("Test completed with failures");
			$finish;
		end
	end

	// input transfers: queue what the block should answer
	always @(posedge clk) begin
		if (arst_n && point_valid && point_ready)
			pending_fields.push_back(row_has_exp ? row_exp : predict_field(point));
	end

	// output transfers: compare with the oldest expectation
	always @(posedge clk) begin
		dfe_pkg::field_t e;
		if (arst_n && field_valid && field_ready) begin
			if (pending_fields.size() == 0) begin
				$display("%0t: unexpected field %h", $time, field);
				errors++;
			end else begin
				e = pending_fields.pop_front();
				if (field.field_x !== e.field_x) begin
					$display("%0t: field_x exp %0d got %0d", $time, e.field_x, field.field_x);
					errors++;
				end
				if (field.field_y !== e.field_y) begin
					$display("%0t: field_y exp %0d got %0d", $time, e.field_y, field.field_y);
					errors++;
				end
				if (field.field_z !== e.field_z) begin
					$display("%0t: field_z exp %0d got %0d", $time, e.field_z, field.field_z);
					errors++;
				end
				if (field.in_gap !== e.in_gap) begin
					$display("%0t: in_gap exp %0b got %0b", $time, e.in_gap, field.in_gap);
					errors++;
				end
			end
		end
	end

	// receiver backpressure: mostly clean runs, some short stalls, a few long
	int ready_hold;
	always @(negedge clk) begin
		if (ready_hold > 0) begin
			ready_hold <= ready_hold - 1;
			field_ready <= 1'b0;
		end else begin
			field_ready <= 1'b1;
			case ($urandom_range(0, 19))
				0, 1, 2: ready_hold <= int'($urandom_range(1, 3));
				3:       ready_hold <= int'($urandom_range(20, 200));
				default: ready_hold <= 0;
			endcase
		end
	end

	function automatic int sender_gap();
		case ($urandom_range(0, 19))
			0, 1, 2, 3: return int'($urandom_range(1, 3));
			4:          return int'($urandom_range(20, 300));
			default:    return 0;
		endcase
	endfunction

	// offer one point; valid stays up into the next point when there is no gap
	task automatic send_point(dfe_pkg::point_t p, logic has_exp, dfe_pkg::field_t exp);
		int gap;
		gap = sender_gap();
		if (gap > 0) begin
			point_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		point       <= p;
		row_has_exp <= has_exp;
		row_exp     <= exp;
		point_valid <= 1'b1;
		do @(posedge clk); while (!point_ready);
		@(negedge clk);
	endtask

	task automatic write_reg(logic [dfe_pkg::REG_IDX_W-1:0] idx, logic [MW-1:0] val);
		@(negedge clk);
		cfg_we   <= 1'b1;
		cfg_idx  <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			dfe_pkg::REG_PEAK: gap_field    = val[31:0];
			dfe_pkg::REG_HLEN: box_half_len = val[dfe_pkg::HALF_W-1:0];
			dfe_pkg::REG_HWID: box_half_wid = val[dfe_pkg::HALF_W-1:0];
			dfe_pkg::REG_MOM:  moment       = val;
			default: ;
		endcase
	endtask

	task automatic drain();
		point_valid <= 1'b0;
		while (pending_fields.size() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	function automatic logic signed [PB-1:0] rand_coord(int lim);
		logic signed [PB-1:0] v;
		v = PB'($urandom_range(0, lim));
		return $urandom_range(0, 1) ? -v : v;
	endfunction

	// random point: in the box, near it, within 100000 of the origin, or anywhere
	function automatic dfe_pkg::point_t rand_point();
		dfe_pkg::point_t p;
		int     hw, hl;
		hw = (box_half_wid > 24'd8388607) ? 8388607 : int'(box_half_wid);
		hl = (box_half_len > 24'd8388607) ? 8388607 : int'(box_half_len);
		case ($urandom_range(0, 9))
			0, 1, 2: begin
				p.pos_x = rand_coord(hw);
				p.pos_y = rand_coord(hw);
				p.pos_z = rand_coord(hl);
			end
			3, 4, 5: begin
				p.pos_x = rand_coord(hw + 2000);
				p.pos_y = rand_coord(hw + 2000);
				p.pos_z = rand_coord(hl + 2000);
			end
			6, 7: begin
				p.pos_x = rand_coord(100000);
				p.pos_y = rand_coord(100000);
				p.pos_z = rand_coord(100000);
			end
			default: begin
				p.pos_x = PB'($urandom);
				p.pos_y = PB'($urandom);
				p.pos_z = PB'($urandom);
			end
		endcase
		return p;
	endfunction

	function automatic row_t mk_row(int x, int y, int z, logic has_exp,
			dfe_pkg::field_t exp);
		row_t r;
		r.p.pos_x = PB'(x);
		r.p.pos_y = PB'(y);
		r.p.pos_z = PB'(z);
		r.has_exp = has_exp;
		r.exp     = exp;
		return r;
	endfunction

	task automatic random_phase(int count);
		dfe_pkg::field_t none;
		none = '0;
		for (int i = 0; i < count; i++) begin
			send_point(rand_point(), 1'b0, none);
			// sender holds off until the block is empty
			if (i == count / 2)
				drain();
		end
		drain();
	endtask

	initial begin
		dfe_pkg::field_t gap_reset;
		dfe_pkg::field_t none;
		arst_n      = 1'b0;
		point_valid = 1'b0;
		point       = '0;
		cfg_we      = 1'b0;
		cfg_idx     = dfe_pkg::REG_PEAK;
		cfg_data    = '0;
		row_has_exp = 1'b0;
		row_exp     = '0;
		gap_field    = dfe_pkg::PEAK_RST;
		box_half_len = dfe_pkg::HLEN_RST;
		box_half_wid = dfe_pkg::HWID_RST;
		moment       = dfe_pkg::MOM_RST;
		none         = '0;
		gap_reset    = '{field_x: 0, field_y: 65536, field_z: 0, in_gap: 1'b1};

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: origin, box edges, just outside, axes, extremes
		rows.push_back(mk_row(0, 0, 0, 1'b1, gap_reset));
		rows.push_back(mk_row(406, 406, 406, 1'b1, gap_reset));
		rows.push_back(mk_row(-406, -406, -406, 1'b1, gap_reset));
		rows.push_back(mk_row(406, -406, 0, 1'b1, gap_reset));
		rows.push_back(mk_row(407, 0, 0, 1'b0, none));
		rows.push_back(mk_row(0, 407, 0, 1'b0, none));
		rows.push_back(mk_row(0, 0, 407, 1'b0, none));
		rows.push_back(mk_row(0, -407, 0, 1'b0, none));
		rows.push_back(mk_row(-407, 0, -407, 1'b0, none));
		rows.push_back(mk_row(500, 500, 500, 1'b0, none));
		rows.push_back(mk_row(-500, 500, -500, 1'b0, none));
		rows.push_back(mk_row(8388607, 8388607, 8388607, 1'b0, none));
		rows.push_back(mk_row(-8388608, -8388608, -8388608, 1'b0, none));
		rows.push_back(mk_row(-8388608, 0, 0, 1'b0, none));
		rows.push_back(mk_row(0, 8388607, 0, 1'b0, none));
		rows.push_back(mk_row(0, 0, -8388608, 1'b0, none));
		rows.push_back(mk_row(1000, 3, -2, 1'b0, none));
		rows.push_back(mk_row(12, 0, 5000, 1'b0, none));
		foreach (rows[i])
			send_point(rows[i].p, rows[i].has_exp, rows[i].exp);
		drain();
		random_phase(RAND_ITEMS);

		// tiny box, largest positive moment, largest peak
		write_reg(dfe_pkg::REG_PEAK, 48'h0000_7FFF_FFFF);
		write_reg(dfe_pkg::REG_HLEN, 48'd0);
		write_reg(dfe_pkg::REG_HWID, 48'd0);
		write_reg(dfe_pkg::REG_MOM, 48'h7FFF_FFFF_FFFF);
		random_phase(RAND_ITEMS);

		// box covers everything, smallest values
		write_reg(dfe_pkg::REG_PEAK, 48'h0000_8000_0000);
		write_reg(dfe_pkg::REG_HLEN, 48'hFF_FFFF);
		write_reg(dfe_pkg::REG_HWID, 48'hFF_FFFF);
		write_reg(dfe_pkg::REG_MOM, 48'h8000_0000_0000);
		random_phase(RAND_ITEMS / 2);

		// negative moment, modest box
		write_reg(dfe_pkg::REG_HLEN, 48'd1000);
		write_reg(dfe_pkg::REG_HWID, 48'd50);
		write_reg(dfe_pkg::REG_MOM, -48'sd1073942626);
		random_phase(RAND_ITEMS);

		// random settings
		write_reg(dfe_pkg::REG_PEAK, MW'({$urandom, $urandom}));
		write_reg(dfe_pkg::REG_HLEN, MW'($urandom_range(0, 4000)));
		write_reg(dfe_pkg::REG_HWID, MW'($urandom_range(0, 4000)));
		write_reg(dfe_pkg::REG_MOM, MW'({$urandom, $urandom}));
		random_phase(RAND_ITEMS);

		drain();
		repeat (20) @(negedge clk);
		if (errors == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

FILE: filelist.f
design/dfe_pkg.sv
design/dfe_front.sv
design/dfe_queue.sv
design/dfe_back.sv
design/dipole_field_evaluator.sv
tb/dipole_field_evaluator_tb.sv
